### hdl/rfa_pkg.sv
package rfa_pkg;

	// operation codes carried in the opcode field
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_MUL = 2'd1,
		OP_EQ  = 2'd2,
		OP_INC = 2'd3
	} rfa_op_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_SUM,
		ST_PREP,
		ST_GCD,
		ST_SHL,
		ST_DIVN,
		ST_DIVD,
		ST_FIN
	} rfa_state_t;

endpackage

### hdl/rfa_if.sv
// operand transaction channel
interface rfa_cmd_if #(parameter int W = 16) ();
	logic         valid;
	logic         ready;
	logic [1:0]   opcode;
	logic [W-1:0] a_num;
	logic [W-1:0] a_den;
	logic [W-1:0] b_num;
	logic [W-1:0] b_den;

	modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

// result transaction channel
interface rfa_rsp_if #(parameter int W = 16) ();
	logic           valid;
	logic           ready;
	logic [2*W:0]   res_num;
	logic [2*W-1:0] res_den;
	logic           is_equal;

	modport source (output valid, res_num, res_den, is_equal, input ready);
	modport sink (input valid, res_num, res_den, is_equal, output ready);
endinterface

### hdl/rfa_mult.sv
module rfa_mult #(
	parameter int W = 16
) (
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] p
);

	// full-width unsigned product, registered by the caller
	assign p = {{W{1'b0}}, a} * {{W{1'b0}}, b};

endmodule

### hdl/rfa_addsub.sv
module rfa_addsub #(
	parameter int WIDTH = 34
) (
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic             sub,
	output logic [WIDTH-1:0] res,
	output logic             ge
);

	logic [WIDTH:0] sum;

	// one carry chain: a + b, or a + ~b + 1; carry out means a >= b when subtracting
	assign sum = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{WIDTH{1'b0}}, sub};
	assign res = sum[WIDTH-1:0];
	assign ge  = sum[WIDTH];

endmodule

### hdl/rational_fraction_alu.sv
// Fraction ALU: one transaction on cmd carries an opcode and two fractions
// a_num/a_den and b_num/b_den; one transaction on rsp returns the result.
// Add, multiply and increment results are reduced by their greatest common
// divisor (a zero numerator or zero denominator is returned unreduced);
// the equality test compares the raw fields and returns zero fractions.
// One operation is in flight at a time and cmd.ready is low while it runs.
// Work is done by a single registered multiplier and a single add/subtract
// unit under a sequencer: up to three products (states ST_MUL0 to ST_MUL2),
// a binary gcd that takes one shift, subtract or swap step per cycle, a left
// shift per common factor of two, and two restoring divisions, one for the
// numerator and one for the denominator.
// The result sits in an output register, so a new operation can start
// while the previous result waits to be taken.
module rational_fraction_alu
	import rfa_pkg::*;
#(
	parameter int OPERAND_WIDTH = 16
) (
	input logic       clk,
	input logic       arst_n,
	rfa_cmd_if.sink   cmd,
	rfa_rsp_if.source rsp
);

	localparam int W  = OPERAND_WIDTH;
	localparam int NW = 2 * W + 1;
	localparam int DW = 2 * W;
	localparam int SW = NW + 1;
	localparam int CW = $clog2(NW + 1);

	rfa_state_t     state_q, state_d;
	rfa_op_t        op_q;
	logic [W-1:0]   an_q, ad_q, bn_q, bd_q;
	logic [NW-1:0]  num_q, den_q;
	logic [DW-1:0]  prod_q;
	logic [NW-1:0]  gx_q, gy_q;
	logic [CW-1:0]  k_q;
	logic [NW-1:0]  quo_q, rem_q;
	logic [CW-1:0]  cnt_q;
	logic           eq_q;
	logic           out_valid_q;
	logic [NW-1:0]  res_num_q;
	logic [DW-1:0]  res_den_q;
	logic           res_eq_q;

	logic           cmd_acc;
	logic           out_load;
	logic           div_last;
	logic [W-1:0]   mul_a, mul_b;
	logic [DW-1:0]  mul_p;
	logic [SW-1:0]  au_a, au_b, au_res;
	logic           au_sub, au_ge;
	logic [NW:0]    div_t;
	logic [NW-1:0]  quo_next;

	assign cmd_acc  = cmd.valid && cmd.ready;
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);
	assign div_last = (cnt_q == CW'(NW - 1));
	assign div_t    = {rem_q, quo_q[NW-1]};
	assign quo_next = {quo_q[NW-2:0], au_ge};

	// shared multiplier
	rfa_mult #(.W(W)) u_mult (
		.a (mul_a),
		.b (mul_b),
		.p (mul_p)
	);

	// shared add/subtract/compare unit
	rfa_addsub #(.WIDTH(SW)) u_addsub (
		.a   (au_a),
		.b   (au_b),
		.sub (au_sub),
		.res (au_res),
		.ge  (au_ge)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					unique case (rfa_op_t'(cmd.opcode))
						OP_EQ:   state_d = ST_FIN;
						OP_INC:  state_d = ST_PREP;
						OP_ADD,
						OP_MUL:  state_d = ST_MUL0;
						default: state_d = ST_MUL0;
					endcase
				end
			end
			ST_MUL0: state_d = ST_MUL1;
			ST_MUL1: state_d = (op_q == OP_ADD) ? ST_MUL2 : ST_PREP;
			ST_MUL2: state_d = ST_SUM;
			ST_SUM:  state_d = ST_PREP;
			ST_PREP: begin
				if (num_q == '0 || den_q == '0) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_GCD;
				end
			end
			ST_GCD: begin
				if (gx_q == '0) begin
					state_d = ST_SHL;
				end
			end
			ST_SHL: begin
				if (k_q == '0) begin
					state_d = ST_DIVN;
				end
			end
			ST_DIVN: begin
				if (div_last) begin
					state_d = ST_DIVD;
				end
			end
			ST_DIVD: begin
				if (div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake and shared unit operand selection
	always_comb begin
		cmd.ready = 1'b0;
		mul_a     = bn_q;
		mul_b     = ad_q;
		au_a      = {1'b0, gx_q};
		au_b      = {1'b0, gy_q};
		au_sub    = 1'b1;
		unique case (state_q)
			ST_IDLE: cmd.ready = 1'b1;
			ST_MUL0: begin
				mul_a = ad_q;
				mul_b = bd_q;
			end
			ST_MUL1: begin
				mul_a = an_q;
				mul_b = (op_q == OP_ADD) ? bd_q : bn_q;
			end
			ST_SUM: begin
				au_a   = {1'b0, num_q};
				au_b   = {2'b00, prod_q};
				au_sub = 1'b0;
			end
			ST_DIVN,
			ST_DIVD: begin
				au_a = div_t;
				au_b = {1'b0, gy_q};
			end
			default: begin
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					op_q <= rfa_op_t'(cmd.opcode);
					an_q <= cmd.a_num;
					ad_q <= cmd.a_den;
					bn_q <= cmd.b_num;
					bd_q <= cmd.b_den;
					eq_q <= (rfa_op_t'(cmd.opcode) == OP_EQ) &&
						(cmd.a_num == cmd.b_num) && (cmd.a_den == cmd.b_den);
					if (rfa_op_t'(cmd.opcode) == OP_INC) begin
						num_q <= NW'({1'b0, cmd.a_num} + {1'b0, cmd.a_den});
						den_q <= NW'(cmd.a_den);
					end else begin
						num_q <= '0;
						den_q <= '0;
					end
				end
			end
			ST_MUL0: den_q <= {1'b0, mul_p};
			ST_MUL1: num_q <= {1'b0, mul_p};
			ST_MUL2: prod_q <= mul_p;
			ST_SUM:  num_q <= au_res[NW-1:0];
			ST_PREP: begin
				gx_q <= num_q;
				gy_q <= den_q;
				k_q  <= '0;
			end
			// binary gcd: strip shared twos, strip lone twos, else subtract or swap
			ST_GCD: begin
				if (gx_q != '0) begin
					if (!gx_q[0] && !gy_q[0]) begin
						gx_q <= gx_q >> 1;
						gy_q <= gy_q >> 1;
						k_q  <= k_q + CW'(1);
					end else if (!gx_q[0]) begin
						gx_q <= gx_q >> 1;
					end else if (!gy_q[0]) begin
						gy_q <= gy_q >> 1;
					end else if (au_ge) begin
						gx_q <= au_res[NW-1:0];
					end else begin
						gx_q <= gy_q;
						gy_q <= gx_q;
					end
				end
			end
			// restore the common factors of two, then set up the numerator division
			ST_SHL: begin
				if (k_q != '0) begin
					gy_q <= gy_q << 1;
					k_q  <= k_q - CW'(1);
				end else begin
					quo_q <= num_q;
					rem_q <= '0;
					cnt_q <= '0;
				end
			end
			// restoring division, one quotient bit per cycle
			ST_DIVN,
			ST_DIVD: begin
				if (div_last) begin
					cnt_q <= '0;
					rem_q <= '0;
					if (state_q == ST_DIVN) begin
						num_q <= quo_next;
						quo_q <= den_q;
					end else begin
						den_q <= quo_next;
					end
				end else begin
					quo_q <= quo_next;
					rem_q <= au_ge ? au_res[NW-1:0] : div_t[NW-1:0];
					cnt_q <= cnt_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			res_num_q <= num_q;
			res_den_q <= den_q[DW-1:0];
			res_eq_q  <= eq_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.res_num  = res_num_q;
	assign rsp.res_den  = res_den_q;
	assign rsp.is_equal = res_eq_q;

endmodule

### hdl/rfa_checker.sv
module rfa_checker #(
	parameter int W = 16
) (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input logic [2*W:0]   res_num,
	input logic [2*W-1:0] res_den,
	input logic           is_equal
);

	// a pending result stays offered until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn before transaction");

	// a pending result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
		$stable(res_num) && $stable(res_den) && $stable(is_equal))
		else $error("result payload changed while stalled");

	// one operation at a time: busy right after taking a command
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("second command taken while busy");

	// an equality result carries a zero fraction
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && is_equal |-> res_num == '0 && res_den == '0)
		else $error("equality result with nonzero fraction");

endmodule

bind rational_fraction_alu rfa_checker #(.W(OPERAND_WIDTH)) u_rfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.res_num   (rsp.res_num),
	.res_den   (rsp.res_den),
	.is_equal  (rsp.is_equal)
);

### tb/fraction_checker.sv
// watches both channels, predicts every result and compares it with what comes out
module fraction_checker
	import rfa_pkg::*;
#(
	parameter int W = 16
) (
	input logic         clk,
	input logic         arst_n,
	rfa_cmd_if          cmd,
	rfa_rsp_if          rsp,
	output int unsigned errors,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		rfa_op_t        op;
		logic [2*W:0]   num;
		logic [2*W-1:0] den;
		logic           eq;
	} frac_res_t;

	// results still owed by the block, oldest first
	frac_res_t frac_q[$];

	// divide out the common factor; zero numerator or denominator is left alone
	function automatic void cancel_common(inout logic [63:0] num, inout logic [63:0] den);
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] r;
		if (num == 0 || den == 0)
			return;
		x = num;
		y = den;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		num = num / x;
		den = den / x;
	endfunction

	function automatic frac_res_t predict_frac(input rfa_op_t op,
			input logic [W-1:0] an, ad, bn, bd);
		logic [63:0] num;
		logic [63:0] den;
		frac_res_t res;
		num = '0;
		den = '0;
		res = '0;
		res.op = op;
		case (op)
			OP_ADD: begin
				num = 64'(an) * 64'(bd) + 64'(bn) * 64'(ad);
				den = 64'(ad) * 64'(bd);
				cancel_common(num, den);
			end
			OP_MUL: begin
				num = 64'(an) * 64'(bn);
				den = 64'(ad) * 64'(bd);
				cancel_common(num, den);
			end
			// raw fields, no reduction
			OP_EQ: begin
				res.eq = (an == bn) && (ad == bd);
			end
			default: begin
				num = 64'(an) + 64'(ad);
				den = 64'(ad);
				cancel_common(num, den);
			end
		endcase
		res.num = num[2*W:0];
		res.den = den[2*W-1:0];
		return res;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
	end

	// compare the finished transaction first, then queue the new one
	always @(posedge clk) begin
		frac_res_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (frac_q.size() == 0) begin
					$display("%0t: result %0d/%0d eq %0d with no operation outstanding",
						$time, rsp.res_num, rsp.res_den, rsp.is_equal);
					errors++;
				end else begin
					want = frac_q.pop_front();
					if (rsp.res_num !== want.num || rsp.res_den !== want.den
							|| rsp.is_equal !== want.eq) begin
						$display("%0t: %s expected %0d/%0d eq %0d, got %0d/%0d eq %0d",
							$time, want.op.name(), want.num, want.den, want.eq,
							rsp.res_num, rsp.res_den, rsp.is_equal);
						errors++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				frac_q.push_back(predict_frac(rfa_op_t'(cmd.opcode),
					cmd.a_num, cmd.a_den, cmd.b_num, cmd.b_den));
			pending = frac_q.size();
		end
	end

endmodule

### tb/rational_fraction_alu_test.sv
module rational_fraction_alu_test
	import rfa_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = 16;
	localparam int RANDOM_OPS = 1530;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 700;
	localparam int DRAIN_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;
	int unsigned errors;
	int unsigned pending;
	int unsigned ops_sent = 0;
	int unsigned idle_cycles = 0;
	bit steady = 1'b0;

	rfa_cmd_if #(.W(W)) cmd_ch ();
	rfa_rsp_if #(.W(W)) rsp_ch ();

	rational_fraction_alu #(.OPERAND_WIDTH(W)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	fraction_checker #(.W(W)) checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// operand values biased toward edges and shared factors
	function automatic logic [W-1:0] pick_value(input bit zero_ok);
		logic [W-1:0] v;
		case ($urandom_range(9))
			0: v = '0;
			1: v = '1;
			2, 3: v = W'($urandom_range(1, 64));
			4: v = W'($urandom_range(1, 15) << $urandom_range(0, W - 4));
			5: v = W'($urandom_range(1, 255) * 12);
			default: v = W'($urandom);
		endcase
		if (!zero_ok && v == 0)
			v = 1;
		return v;
	endfunction

	// denominators are zero only now and then
	function automatic logic [W-1:0] pick_den();
		if ($urandom_range(99) == 0)
			return '0;
		return pick_value(1'b0);
	endfunction

	// offer one transaction, starting just after a falling edge
	task automatic send_op(input rfa_op_t op, input logic [W-1:0] an, ad, bn, bd);
		while (!steady && $urandom_range(99) < 37) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid  <= 1'b1;
		cmd_ch.opcode <= op;
		cmd_ch.a_num  <= an;
		cmd_ch.a_den  <= ad;
		cmd_ch.b_num  <= bn;
		cmd_ch.b_den  <= bd;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		ops_sent++;
		@(negedge clk);
	endtask

	// receiver: random back-pressure plus two long hold-offs
	initial begin
		int unsigned hold_left;
		bit held_first;
		bit held_second;
		hold_left = 0;
		held_first = 1'b0;
		held_second = 1'b0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_left == 0 && !held_first && ops_sent >= 400) begin
				held_first = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left == 0 && !held_second && ops_sent >= 1200) begin
				held_second = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= steady || ($urandom_range(99) >= 37);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// stimulus and verdict
	initial begin
		rfa_op_t op;
		logic [W-1:0] an;
		logic [W-1:0] ad;
		logic [W-1:0] bn;
		logic [W-1:0] bd;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = OP_ADD;
		cmd_ch.a_num = '0;
		cmd_ch.a_den = '0;
		cmd_ch.b_num = '0;
		cmd_ch.b_den = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// add: extremes, zero numerators, zero denominator
		send_op(OP_ADD, '1, '1, '1, '1);
		send_op(OP_ADD, '1, 1, '1, 1);
		send_op(OP_ADD, 1, '1, 1, 16'hfffe);
		send_op(OP_ADD, 0, 6, 0, 3);
		send_op(OP_ADD, 1, 2, 1, 2);
		send_op(OP_ADD, 3, 0, 2, 5);
		// multiply
		send_op(OP_MUL, '1, '1, '1, '1);
		send_op(OP_MUL, 0, 7, 5, 3);
		send_op(OP_MUL, '1, 1, '1, 1);
		send_op(OP_MUL, 2, 3, 3, 0);
		send_op(OP_MUL, 1, '1, 1, '1);
		// equality compares raw fields
		send_op(OP_EQ, 1, 2, 1, 2);
		send_op(OP_EQ, 1, 2, 2, 4);
		send_op(OP_EQ, 5, 7, 5, 8);
		send_op(OP_EQ, 5, 7, 6, 7);
		send_op(OP_EQ, '1, '1, '1, '1);
		send_op(OP_EQ, 0, 0, 0, 0);
		// increment, b fields are don't-care
		send_op(OP_INC, 0, 6, '1, '1);
		send_op(OP_INC, '1, '1, 0, 0);
		send_op(OP_INC, '1, 1, 16'h5a5a, 16'ha5a5);
		send_op(OP_INC, 4, 6, 1, 1);
		send_op(OP_INC, 5, 0, 3, 9);

		// random operations, one idle-free stretch in the middle
		for (int i = 0; i < RANDOM_OPS; i++) begin
			steady = (i >= 800 && i < 1000);
			op = rfa_op_t'($urandom_range(3));
			an = pick_value(1'b1);
			ad = pick_den();
			bn = pick_value(1'b1);
			bd = pick_den();
			if (op == OP_EQ) begin
				case ($urandom_range(3))
					0, 1: begin
						bn = an;
						bd = ad;
					end
					2: bn = an;
					default: bd = ad;
				endcase
			end
			send_op(op, an, ad, bn, bd);
		end
		steady = 1'b0;
		cmd_ch.valid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			if (pending != 0)
				$display("%0t: %0d results never arrived", $time, pending);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
